// ===== design/hav_pkg.sv =====
package hav_pkg;

  // rotator / vectoring datapath width (Q30 with headroom)
  localparam int RW = 34;

  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
  localparam logic [32:0] HALF_K   = 33'((PI_Q62 + 64'd1800000000) / 64'd3600000000);
  localparam logic [32:0] FULL_K   = 33'((PI_Q62 + 64'd900000000) / 64'd1800000000);

  localparam logic [32:0] TURN_U    = 33'd3600000000;
  localparam logic [31:0] HALF_U    = 32'd1800000000;
  localparam logic [30:0] QUARTER_U = 31'd900000000;

  localparam logic signed [RW-1:0] START_X = 34'sh026DD3B6A;
  localparam logic [30:0] Q30_ONE  = 31'h40000000;
  localparam logic [60:0] Q60_ONE  = 61'h1000000000000000;
  localparam logic [30:0] DIST_MAX = 31'd2010619300;
  localparam logic [22:0] RADIUS_RESET = 23'd6371000;

  // floor square root of a 62-bit word, one bit of root per step
  localparam int SQRT_STEPS = 31;

  // rotator lanes
  localparam int L_SLAT = 0;
  localparam int L_SLON = 1;
  localparam int L_COWN = 2;
  localparam int L_CTGT = 3;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // clamp a CORDIC output to [0, 1] in Q30
  function automatic logic [30:0] clamp_unit(input logic signed [RW-1:0] v);
    logic [30:0] r;
    if (v[RW-1]) begin
      r = '0;
    end else if (v > $signed({3'b000, Q30_ONE})) begin
      r = Q30_ONE;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

// ===== design/haversine_distance.sv =====
// Channel  Dir  Beat fields (low bit up)                              Handshake
// s_*      in   own_lat[30:0] own_lon[62:31] target_lat[93:63]       tvalid/tready
//               target_lon[125:94], zero pad to 128
// m_*      out  distance_cm[30:0], zero pad to 32                    tvalid/tready
// cfg_*    in   earth_radius_m[22:0]                                 valid/ready
//
// One beat per cycle sustained while the output is taken. The two CORDIC
// chains and the 31-step square root set the pipeline depth; every stage
// is one register.
// Reset clears all valid bits and loads the default radius.
// Each stage holds while the one after it is full and stalled, so bubbles
// collapse and the input takes beats while a result waits until all stages fill.
module haversine_distance #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [127:0] s_tdata_i,   // own_lat, own_lon, target_lat, target_lon
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [31:0]  m_tdata_o,   // distance_cm
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [22:0]  cfg_data_i   // earth_radius_m
);
  import hav_pkg::*;

  localparam int N       = CORDIC_STAGES;
  localparam int P_ROT0  = 6;
  localparam int P_CLMP  = P_ROT0 + N;
  localparam int P_SQ    = P_CLMP + 1;
  localparam int P_RSQ   = P_CLMP + 2;
  localparam int P_HMUL  = P_CLMP + 3;
  localparam int P_HAV   = P_CLMP + 4;
  localparam int P_REST  = P_CLMP + 5;
  localparam int P_SQRT0 = P_CLMP + 6;
  localparam int P_VEC0  = P_SQRT0 + SQRT_STEPS;
  localparam int P_CENT  = P_VEC0 + N;
  localparam int P_DMUL  = P_CENT + 1;
  localparam int P_OUT   = P_CENT + 2;
  localparam int NST     = P_OUT + 1;

  // ---------------- stage control ----------------
  logic [NST-1:0] v_q;
  logic [NST:0]   ld;     // stage k loads this cycle

  assign ld[NST] = m_tready_i;
  for (genvar k = 0; k < NST; k++) begin : g_ctl
    assign ld[k] = !v_q[k] || ld[k+1];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (ld[k]) begin
        if (k == 0) begin
          v_q[k] <= s_tvalid_i;
        end else begin
          v_q[k] <= v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_tready_o = ld[0];
  assign m_tvalid_o = v_q[NST-1];

  // ---------------- radius register ----------------
  logic [22:0] radius_q;
  logic [29:0] r100_q;    // radius * 100, in centimetres

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      r100_q   <= 30'({7'd0, RADIUS_RESET} * 30'd100);
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
      r100_q   <= 30'({7'd0, cfg_data_i} * 30'd100);
    end
  end

  // ---------------- front end: differences and angle folding ----------------
  logic signed [30:0] own_lat, tgt_lat;
  logic signed [31:0] own_lon, tgt_lon;
  assign own_lat = s_tdata_i[30:0];
  assign own_lon = s_tdata_i[62:31];
  assign tgt_lat = s_tdata_i[93:63];
  assign tgt_lon = s_tdata_i[125:94];

  logic signed [31:0] dlat_q;
  logic signed [32:0] dlon_q;
  logic [30:0] alat_o_q, alat_t_q;
  logic [31:0] adlat1_q, adlat2_q;
  logic [32:0] adlon1_q;
  logic [31:0] adlon2_q;
  logic [30:0] ulat_o_q, ulat_t_q, ulat_o2_q, ulat_t2_q;
  logic [1:0]  fl1_q, fl2_q, fl3_q, fl4_q, fl5_q;
  logic [30:0] u_q  [4];
  logic [63:0] mp_q [4];
  logic [31:0] z_q  [4];
  logic [63:0] rnd  [4];
  logic [32:0] kk   [4];

  assign kk[L_SLAT] = HALF_K;
  assign kk[L_SLON] = HALF_K;
  assign kk[L_COWN] = FULL_K;
  assign kk[L_CTGT] = FULL_K;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      dlat_q   <= 32'(own_lat) - 32'(tgt_lat);
      dlon_q   <= 33'(own_lon) - 33'(tgt_lon);
      alat_o_q <= own_lat[30] ? 31'(-own_lat) : own_lat;
      alat_t_q <= tgt_lat[30] ? 31'(-tgt_lat) : tgt_lat;
    end
    if (ld[1]) begin
      adlat1_q <= dlat_q[31] ? 32'(-dlat_q) : dlat_q;
      adlon1_q <= dlon_q[32] ? 33'(-dlon_q) : dlon_q;
      // latitudes past the pole keep the cosine sign through a flip
      fl1_q    <= {alat_t_q > QUARTER_U, alat_o_q > QUARTER_U};
      ulat_o_q <= (alat_o_q > QUARTER_U) ? 31'(HALF_U) - alat_o_q : alat_o_q;
      ulat_t_q <= (alat_t_q > QUARTER_U) ? 31'(HALF_U) - alat_t_q : alat_t_q;
    end
    if (ld[2]) begin
      adlat2_q  <= adlat1_q;
      adlon2_q  <= (adlon1_q >= TURN_U) ? 32'(adlon1_q - TURN_U) : adlon1_q[31:0];
      ulat_o2_q <= ulat_o_q;
      ulat_t2_q <= ulat_t_q;
      fl2_q     <= fl1_q;
    end
    if (ld[3]) begin
      u_q[L_SLAT] <= (adlat2_q > HALF_U) ? 31'(TURN_U - 33'(adlat2_q)) : adlat2_q[30:0];
      u_q[L_SLON] <= (adlon2_q > HALF_U) ? 31'(TURN_U - 33'(adlon2_q)) : adlon2_q[30:0];
      u_q[L_COWN] <= ulat_o2_q;
      u_q[L_CTGT] <= ulat_t2_q;
      fl3_q       <= fl2_q;
    end
    if (ld[4]) begin
      for (int l = 0; l < 4; l++) begin
        mp_q[l] <= {33'd0, u_q[l]} * {31'd0, kk[l]};
      end
      fl4_q <= fl3_q;
    end
    if (ld[5]) begin
      for (int l = 0; l < 4; l++) begin
        z_q[l] <= rnd[l][63:32];
      end
      fl5_q <= fl4_q;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rnd[l] = mp_q[l] + 64'h0000_0000_8000_0000;
    end
  end

  // ---------------- rotation CORDIC, four lanes ----------------
  logic signed [RW-1:0] rx_q [N][4];
  logic signed [RW-1:0] ry_q [N][4];
  logic signed [RW-1:0] rz_q [N][4];
  logic [1:0]           rf_q [N];

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [RW-1:0] xi [4];
    logic signed [RW-1:0] yi [4];
    logic signed [RW-1:0] zi [4];
    logic [1:0]           fi;
    logic signed [RW-1:0] at;
    assign at = $signed({2'b00, atan_q30(5'(i))});
    if (i == 0) begin : g_first
      for (genvar l = 0; l < 4; l++) begin : g_l
        assign xi[l] = START_X;
        assign yi[l] = '0;
        assign zi[l] = $signed({2'b00, z_q[l]});
      end
      assign fi = fl5_q;
    end else begin : g_next
      for (genvar l = 0; l < 4; l++) begin : g_l
        assign xi[l] = rx_q[i-1][l];
        assign yi[l] = ry_q[i-1][l];
        assign zi[l] = rz_q[i-1][l];
      end
      assign fi = rf_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (ld[P_ROT0+i]) begin
        for (int l = 0; l < 4; l++) begin
          if (!zi[l][RW-1]) begin
            rx_q[i][l] <= xi[l] - (yi[l] >>> i);
            ry_q[i][l] <= yi[l] + (xi[l] >>> i);
            rz_q[i][l] <= zi[l] - at;
          end else begin
            rx_q[i][l] <= xi[l] + (yi[l] >>> i);
            ry_q[i][l] <= yi[l] - (xi[l] >>> i);
            rz_q[i][l] <= zi[l] + at;
          end
        end
        rf_q[i] <= fi;
      end
    end
  end

  // ---------------- haversine term ----------------
  logic [30:0]        sl_q, sn_q, c_own, c_tgt;
  logic signed [31:0] co_q, ct_q;
  logic signed [63:0] pcos_q;
  logic [61:0]        plon_q, plat_q, plat2_q, plat3_q;
  logic signed [31:0] cprod_q;
  logic [30:0]        lonsq_q;
  logic signed [63:0] hp_q;
  logic [60:0]        hav_q;
  logic [60:0]        sqv_q [2];
  logic signed [63:0] pcos_r, hsum;
  logic [61:0]        plon_r;

  assign c_own  = clamp_unit(rx_q[N-1][L_COWN]);
  assign c_tgt  = clamp_unit(rx_q[N-1][L_CTGT]);
  assign pcos_r = pcos_q + 64'sd536870912;
  assign plon_r = plon_q + 62'd536870912;
  assign hsum   = $signed({2'b00, plat3_q}) + hp_q;

  always_ff @(posedge clk_i) begin
    if (ld[P_CLMP]) begin
      sl_q <= clamp_unit(ry_q[N-1][L_SLAT]);
      sn_q <= clamp_unit(ry_q[N-1][L_SLON]);
      co_q <= rf_q[N-1][0] ? -$signed({1'b0, c_own}) : $signed({1'b0, c_own});
      ct_q <= rf_q[N-1][1] ? -$signed({1'b0, c_tgt}) : $signed({1'b0, c_tgt});
    end
    if (ld[P_SQ]) begin
      pcos_q <= 64'(co_q) * 64'(ct_q);
      plon_q <= {31'd0, sn_q} * {31'd0, sn_q};
      plat_q <= {31'd0, sl_q} * {31'd0, sl_q};
    end
    if (ld[P_RSQ]) begin
      cprod_q <= pcos_r[61:30];
      lonsq_q <= plon_r[60:30];
      plat2_q <= plat_q;
    end
    if (ld[P_HMUL]) begin
      hp_q    <= 64'(cprod_q) * 64'($signed({1'b0, lonsq_q}));
      plat3_q <= plat2_q;
    end
    if (ld[P_HAV]) begin
      if (hsum[63]) begin
        hav_q <= '0;
      end else if (hsum > $signed({3'b000, Q60_ONE})) begin
        hav_q <= Q60_ONE;
      end else begin
        hav_q <= hsum[60:0];
      end
    end
    if (ld[P_REST]) begin
      sqv_q[0] <= hav_q;
      sqv_q[1] <= Q60_ONE - hav_q;
    end
  end

  // ---------------- square roots, two lanes, one root bit per stage ----------------
  logic [32:0] sr_rem  [SQRT_STEPS][2];
  logic [30:0] sr_root [SQRT_STEPS][2];
  logic [61:0] sr_val  [SQRT_STEPS][2];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [32:0] remi  [2];
    logic [30:0] rooti [2];
    logic [61:0] vali  [2];
    logic [34:0] remx  [2];
    logic [34:0] trial [2];
    for (genvar l = 0; l < 2; l++) begin : g_l
      if (j == 0) begin : g_first
        assign remi[l]  = '0;
        assign rooti[l] = '0;
        assign vali[l]  = {1'b0, sqv_q[l]};
      end else begin : g_next
        assign remi[l]  = sr_rem[j-1][l];
        assign rooti[l] = sr_root[j-1][l];
        assign vali[l]  = sr_val[j-1][l];
      end
      assign remx[l]  = {remi[l], vali[l][61:60]};
      assign trial[l] = {2'b00, rooti[l], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (ld[P_SQRT0+j]) begin
        for (int l = 0; l < 2; l++) begin
          sr_val[j][l] <= {vali[l][59:0], 2'b00};
          if (remx[l] >= trial[l]) begin
            sr_rem[j][l]  <= 33'(remx[l] - trial[l]);
            sr_root[j][l] <= {rooti[l][29:0], 1'b1};
          end else begin
            sr_rem[j][l]  <= remx[l][32:0];
            sr_root[j][l] <= {rooti[l][29:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- vectoring CORDIC: atan2(sqrt h, sqrt(1-h)) ----------------
  logic signed [RW-1:0] vx_q [N];
  logic signed [RW-1:0] vy_q [N];
  logic signed [RW-1:0] vz_q [N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [RW-1:0] xi, yi, zi, at;
    assign at = $signed({2'b00, atan_q30(5'(i))});
    if (i == 0) begin : g_first
      assign xi = $signed({3'b000, sr_root[SQRT_STEPS-1][1]});
      assign yi = $signed({3'b000, sr_root[SQRT_STEPS-1][0]});
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (ld[P_VEC0+i]) begin
        if (yi > 0) begin
          vx_q[i] <= xi + (yi >>> i);
          vy_q[i] <= yi - (xi >>> i);
          vz_q[i] <= zi + at;
        end else begin
          vx_q[i] <= xi - (yi >>> i);
          vy_q[i] <= yi + (xi >>> i);
          vz_q[i] <= zi - at;
        end
      end
    end
  end

  // ---------------- scale by radius and saturate ----------------
  logic [31:0] cent_q;     // central angle, Q30
  logic [61:0] dp_q;
  logic [30:0] out_q;
  logic [62:0] dsum;

  assign dsum = {1'b0, dp_q} + 63'd536870912;

  always_ff @(posedge clk_i) begin
    if (ld[P_CENT]) begin
      // CORDIC residue can leave a tiny negative angle
      cent_q <= vz_q[N-1][RW-1] ? 32'd0 : {vz_q[N-1][30:0], 1'b0};
    end
    if (ld[P_DMUL]) begin
      dp_q <= {32'd0, r100_q} * {30'd0, cent_q};
    end
    if (ld[P_OUT]) begin
      out_q <= (dsum[62:30] > {2'b00, DIST_MAX}) ? DIST_MAX : dsum[60:30];
    end
  end

  assign m_tdata_o = {1'b0, out_q};

  // ---------------- assertions ----------------
  // a ready output lets every stage advance, so the input side must be open
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_tready_i |-> s_tready_o)
    else $error("input stalled while output drains");

  // an empty pipeline with no new beat cannot produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0 && !s_tvalid_i) |=> !m_tvalid_o)
    else $error("result from empty pipeline");

  // scaled radius tracks the written radius
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> (r100_q == 30'({7'd0, radius_q} * 30'd100)))
    else $error("radius scale out of step");

endmodule

// ===== dv/haversine_checker.sv =====
`timescale 1ns / 100ps

// Watches the position, result and radius channels of haversine_distance,
// predicts each distance and checks results in order.
module haversine_checker #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [127:0] s_tdata_i,   // own_lat, own_lon, target_lat, target_lon
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [31:0]  m_tdata_i,   // distance_cm
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [22:0]  cfg_data_i,  // earth_radius_m
  output int           mismatches_o,
  output int           outstanding_o
);

  localparam longint unsigned PI_Q62      = 64'hC90FDAA22168C234;
  localparam longint unsigned K_HALF      = (PI_Q62 + 64'd1800000000) / 64'd3600000000;
  localparam longint unsigned K_FULL      = (PI_Q62 + 64'd900000000) / 64'd1800000000;
  localparam longint          TURN        = 64'sd3600000000;
  localparam longint          HALF_TURN   = 64'sd1800000000;
  localparam longint          QUARTER     = 64'sd900000000;
  localparam longint          ONE_Q30     = 64'sd1 << 30;
  localparam longint          ONE_Q60     = 64'sd1 << 60;
  localparam longint          INV_GAIN    = 64'sh26DD3B6A;
  localparam longint unsigned MAX_CM      = 64'd2010619300;

  localparam longint ARCTAN [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
    64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000
  };

  logic [22:0]  radius_m;
  logic [30:0]  distance_q[$];

  function automatic longint unit_clamp(input longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  // rotation mode: returns sine when want_sin, else cosine
  function automatic longint rotate(input longint ang, input bit want_sin);
    longint x, y, z, dx, dy;
    x = INV_GAIN;
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN[i];
      end
    end
    return want_sin ? unit_clamp(y) : unit_clamp(x);
  endfunction

  function automatic longint vector_angle(input longint x0, input longint y0);
    longint x, y, z, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ARCTAN[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sin of half the difference, difference folded into [0, 180] degrees
  function automatic longint half_diff_sine(input longint diff);
    longint u;
    longint unsigned z;
    u = diff % TURN;
    if (u < 0) u = -u;
    if (u > HALF_TURN) u = TURN - u;
    z = (longint'(u) * K_HALF + (64'd1 << 31)) >> 32;
    return rotate(longint'(z), 1'b1);
  endfunction

  // cosine keeps its sign past 90 degrees
  function automatic longint lat_cosine(input longint lat);
    longint u, c;
    longint unsigned z;
    bit flip;
    u = lat < 0 ? -lat : lat;
    flip = u > QUARTER;
    if (flip) u = HALF_TURN - u;
    z = (longint'(u) * K_FULL + (64'd1 << 31)) >> 32;
    c = rotate(longint'(z), 1'b0);
    return flip ? -c : c;
  endfunction

  function automatic logic [30:0] great_circle_cm(input logic [127:0] beat,
                                                  input logic [22:0] radius);
    longint olat, olon, tlat, tlon, s_lat, s_lon, cprod, lon_sq, h, central;
    longint unsigned dist_cm;
    olat  = longint'($signed(beat[30:0]));
    olon  = longint'($signed(beat[62:31]));
    tlat  = longint'($signed(beat[93:63]));
    tlon  = longint'($signed(beat[125:94]));
    s_lat = half_diff_sine(olat - tlat);
    s_lon = half_diff_sine(olon - tlon);
    cprod = (lat_cosine(olat) * lat_cosine(tlat) + (64'sd1 << 29)) >>> 30;
    lon_sq = (s_lon * s_lon + (64'sd1 << 29)) >>> 30;
    h = s_lat * s_lat + cprod * lon_sq;
    if (h < 0) h = 0;
    if (h > ONE_Q60) h = ONE_Q60;
    central = vector_angle(longint'(floor_sqrt(ONE_Q60 - h)), longint'(floor_sqrt(h)));
    if (central < 0) central = 0;
    central *= 2;
    dist_cm = (longint'(radius) * 100 * longint'(central) + (64'd1 << 29)) >> 30;
    if (dist_cm > MAX_CM) dist_cm = MAX_CM;
    return dist_cm[30:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [30:0] want;
    if (!rst_ni) begin
      radius_m = 23'd6371000;
      distance_q.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) radius_m = cfg_data_i;
      if (s_tvalid_i && s_tready_i) distance_q.push_back(great_circle_cm(s_tdata_i, radius_m));
      if (m_tvalid_i && m_tready_i) begin
        if (distance_q.size() == 0) begin
          $error("unexpected result beat: distance_cm %0d", m_tdata_i[30:0]);
          mismatches_o++;
        end else begin
          want = distance_q.pop_front();
          if (m_tdata_i[30:0] !== want) begin
            $error("distance_cm: expected %0d, actual %0d", want, m_tdata_i[30:0]);
            mismatches_o++;
          end
          if (m_tdata_i[31] !== 1'b0) begin
            $error("pad: expected 0, actual %b", m_tdata_i[31]);
            mismatches_o++;
          end
        end
      end
    end
    outstanding_o = distance_q.size();
  end

endmodule

// ===== dv/tb_haversine_distance.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for haversine_distance; checking lives in haversine_checker.
module tb_haversine_distance;

  localparam int LATENCY = 2 * 24 + 46;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [127:0] s_tdata_i = '0;   // own_lat, own_lon, target_lat, target_lon
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [31:0]  m_tdata_o;        // distance_cm
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [22:0]  cfg_data_i = '0;  // earth_radius_m

  int  mismatches, outstanding;
  bit  gaps_on = 1'b1;   // random idling on both sides
  bit  sink_hold = 1'b0; // request a long receiver stall

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  haversine_distance dut (.*);

  haversine_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  // receiver: random back-pressure, or a long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        m_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        sink_hold = 1'b0;
      end else begin
        m_tready_i <= !(gaps_on && $urandom_range(99) < 17);
      end
    end
  end

  // one position pair; the beat stays up until taken, then maybe a one-cycle gap
  task automatic send_pair(input logic [30:0] olat, input logic [31:0] olon,
                           input logic [30:0] tlat, input logic [31:0] tlon);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {2'b00, tlon, tlat, olon, olat};
    do @(posedge clk_i); while (!s_tready_o);
    if (gaps_on && $urandom_range(99) < 20) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // radius written only with the pipe empty
  task automatic set_radius(input logic [22:0] r);
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [30:0] rnd_lat();
    return 31'($signed($urandom_range(1800000000)) - 900000000);
  endfunction

  function automatic logic [31:0] rnd_lon();
    return 32'($urandom_range(3600000000) - 32'd1800000000);
  endfunction

  task automatic random_pairs(input int n);
    logic [30:0] olat, tlat;
    logic [31:0] olon, tlon;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      olat = rnd_lat();
      olon = rnd_lon();
      if (pick < 55) begin
        tlat = rnd_lat();
        tlon = rnd_lon();
      end else if (pick < 80) begin
        // nearby target: small deltas
        tlat = olat + 31'($signed($urandom_range(200000)) - 100000);
        tlon = olon + 32'($signed($urandom_range(200000)) - 100000);
      end else begin
        // whole field width, beyond the stated ranges too
        olat = 31'($urandom);
        tlat = 31'($urandom);
        olon = $urandom;
        tlon = $urandom;
      end
      send_pair(olat, olon, tlat, tlon);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, same point, antipodes, lat past the pole
    send_pair('0, '0, '0, '0);
    send_pair(31'sd450000000, 32'sd100000000, 31'sd450000000, 32'sd100000000);
    send_pair('0, '0, '0, 32'sd1800000000);
    send_pair('0, -32'sd1800000000, '0, 32'sd1800000000);
    send_pair(31'sd900000000, '0, -31'sd900000000, '0);
    send_pair(31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
    send_pair(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
    send_pair(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
    send_pair(31'h7FFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_pair(31'sd950000000, '0, 31'sd10000000, 32'sd5000000);
    send_pair(-31'sd1000000000, 32'sd900000000, 31'sd1000000000, -32'sd900000000);
    send_pair('0, '0, 31'sd1, 32'sd1);
    send_pair(31'sd123456789, -32'sd987654321, -31'sd555555555, 32'sd1234567890);

    set_radius(23'h7FFFFF);  // saturates the antipodes
    send_pair('0, '0, '0, 32'sd1800000000);
    send_pair(31'sd900000000, '0, -31'sd900000000, '0);
    set_radius('0);
    send_pair('0, '0, '0, 32'sd1800000000);
    send_pair(31'sd300000000, 32'sd700000000, -31'sd200000000, -32'sd100000000);

    set_radius(23'd6300000);
    random_pairs(200);

    // long receiver stall while the sender keeps offering
    sink_hold = 1'b1;
    random_pairs(150);
    drain();  // sender waits for every result

    set_radius(23'd6400000);
    gaps_on = 1'b0;  // back-to-back stretch
    random_pairs(200);
    gaps_on = 1'b1;

    set_radius(23'($urandom));
    random_pairs(150);
    set_radius(23'd6371000);
    random_pairs(250);

    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS haversine_distance");
    end else begin
      $display("FAIL haversine_distance");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL haversine_distance");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hav_pkg.sv
design/haversine_distance.sv
dv/haversine_checker.sv
dv/tb_haversine_distance.sv
